FILE: sv/pdl_pkg.sv
// ----------------------------------------------------------------------------
// pdl_pkg: shared types and constants for the password door lock controller
// Transfer payload structs, action/reply/motor codes, password geometry.
// ----------------------------------------------------------------------------
package pdl_pkg;

  localparam int unsigned PasswordLen = 5;
  localparam int unsigned IdxW        = (PasswordLen > 1) ? $clog2(PasswordLen) : 1;
  localparam int unsigned CntW        = $clog2(PasswordLen + 1);

  localparam int unsigned TickW   = 16;
  localparam int unsigned AttW    = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  // action codes
  localparam logic [1:0] ActDigit   = 2'd0;
  localparam logic [1:0] ActCommand = 2'd1;
  localparam logic [1:0] ActTick    = 2'd2;
  localparam logic [1:0] ActLinkErr = 2'd3;

  // reply codes
  localparam logic [1:0] RcGranted = 2'd0;
  localparam logic [1:0] RcDenied  = 2'd1;
  localparam logic [1:0] RcAlert   = 2'd2;
  localparam logic [1:0] RcLocking = 2'd3;

  // motor drive codes
  localparam logic [1:0] MotorStop  = 2'd0;
  localparam logic [1:0] MotorOpen  = 2'd1;
  localparam logic [1:0] MotorClose = 2'd2;

  // config register indexes
  localparam logic [CfgIdxW-1:0] CfgDoorMoveTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAlertTicks    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxAttempts   = 2'd2;

  localparam logic [TickW-1:0] DoorMoveTicksRst = 16'd15;
  localparam logic [TickW-1:0] AlertTicksRst    = 16'd60;
  localparam logic [AttW-1:0]  MaxAttemptsRst   = 3'd3;

  typedef enum logic [8:0] {
    PhNewPw     = 9'b000000001,
    PhIdle      = 9'b000000010,
    PhVerUnlock = 9'b000000100,
    PhVerChange = 9'b000001000,
    PhAlert     = 9'b000010000,
    PhOpening   = 9'b000100000,
    PhWaitClear = 9'b001000000,
    PhClosing   = 9'b010000000,
    PhHalted    = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] digit_value;
    logic       cmd_unlock;
    logic       motion_seen;
  } pdl_in_t;

  typedef struct packed {
    logic       reply_valid;
    logic [1:0] reply_code;
    logic [1:0] motor_drive;
    logic       buzzer_active;
    logic       halted;
  } pdl_out_t;

endpackage

FILE: sv/password_door_lock_controller.sv
// ----------------------------------------------------------------------------
// password_door_lock_controller: password entry, verify and door sequencing
// Takes digits, commands, timer ticks and link errors; answers each with
// one result carrying the reply code and the motor/buzzer/halt levels.
// ----------------------------------------------------------------------------
//
//  channel | signals                               | dir | note
//  --------+---------------------------------------+-----+----------------------
//  in      | in_valid_i in_ready_o in_data_i       | in  | one event per transfer
//  out     | out_valid_o out_ready_i out_data_o    | out | one result per event
//  cfg     | cfg_we_i cfg_index_i cfg_wdata_i      | in  | write only, no wait
//
//  Each input transfer is handled directly: the phase update and the
//  result are computed from the accepted item and land in the result
//  register at the same edge, so the result shows in the next cycle.
//  One item per cycle is sustained while the sink takes results; the only
//  stall is a held result (in_ready_o follows out_ready_i when full).
//  Reset (rst_ni low, async) enters new-password entry with default timing.
//  The password stores are plain registers without reset; they are always
//  written before they are read.
module password_door_lock_controller
  import pdl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pdl_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pdl_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // config registers
  logic [TickW-1:0] door_move_ticks_q;
  logic [TickW-1:0] alert_ticks_q;
  logic [AttW-1:0]  max_attempts_q;

  // control state
  phase_e           phase_q, phase_d;
  logic [IdxW-1:0]  digit_index_q, digit_index_d;
  logic             second_q, second_d;
  logic             mismatch_q, mismatch_d;
  logic [AttW-1:0]  attempt_q, attempt_d;
  logic [TickW-1:0] tick_q, tick_d;

  // password stores
  logic [7:0] stored_pw_q [PasswordLen];
  logic [7:0] first_entry_q [PasswordLen];
  logic       fe_we;
  logic       sp_copy;

  // result register
  logic     out_valid_q;
  pdl_out_t out_data_q;
  pdl_out_t res;

  logic             accept;
  logic             last_digit;
  logic [TickW-1:0] tick_inc;
  logic [AttW:0]    attempt_inc;
  logic             fe_mis;
  logic             sp_mis;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign last_digit  = ({1'b0, digit_index_q} + (IdxW+1)'(1)) >= (IdxW+1)'(PasswordLen);
  assign tick_inc    = tick_q + TickW'(1);
  assign attempt_inc = {1'b0, attempt_q} + (AttW+1)'(1);
  assign fe_mis      = first_entry_q[digit_index_q] != in_data_i.digit_value;
  assign sp_mis      = stored_pw_q[digit_index_q] != in_data_i.digit_value;

  always_comb begin
    phase_d         = phase_q;
    digit_index_d   = digit_index_q;
    second_d        = second_q;
    mismatch_d      = mismatch_q;
    attempt_d       = attempt_q;
    tick_d          = tick_q;
    fe_we           = 1'b0;
    sp_copy         = 1'b0;
    res.reply_valid = 1'b0;
    res.reply_code  = RcGranted;

    if (phase_q == PhHalted) begin
      // frozen until reset
    end else if (in_data_i.action == ActLinkErr) begin
      phase_d = PhHalted;
    end else if (in_data_i.action == ActDigit) begin
      if (phase_q == PhNewPw) begin
        if (!second_q) begin
          fe_we = 1'b1;
          if (last_digit) begin
            digit_index_d = '0;
            second_d      = 1'b1;
            mismatch_d    = 1'b0;
          end else begin
            digit_index_d = digit_index_q + IdxW'(1);
          end
        end else begin
          if (last_digit) begin
            res.reply_valid = 1'b1;
            if (!(mismatch_q || fe_mis)) begin
              sp_copy        = 1'b1;
              res.reply_code = RcGranted;
              phase_d        = PhIdle;
            end else begin
              res.reply_code = RcDenied;
            end
            digit_index_d = '0;
            second_d      = 1'b0;
            mismatch_d    = 1'b0;
          end else begin
            mismatch_d    = mismatch_q || fe_mis;
            digit_index_d = digit_index_q + IdxW'(1);
          end
        end
      end else if (phase_q == PhVerUnlock || phase_q == PhVerChange) begin
        fe_we = 1'b1;
        if (last_digit) begin
          res.reply_valid = 1'b1;
          if (!(mismatch_q || sp_mis)) begin
            res.reply_code = RcGranted;
            tick_d         = '0;
            phase_d        = (phase_q == PhVerUnlock) ? PhOpening : PhNewPw;
          end else if (attempt_inc >= {1'b0, max_attempts_q}) begin
            // last miss: alert mode
            res.reply_code = RcAlert;
            tick_d         = '0;
            phase_d        = PhAlert;
          end else begin
            res.reply_code = RcDenied;
            attempt_d      = attempt_inc[AttW-1:0];
          end
          digit_index_d = '0;
          second_d      = 1'b0;
          mismatch_d    = 1'b0;
        end else begin
          mismatch_d    = mismatch_q || sp_mis;
          digit_index_d = digit_index_q + IdxW'(1);
        end
      end
    end else if (in_data_i.action == ActCommand) begin
      if (phase_q == PhIdle) begin
        digit_index_d = '0;
        second_d      = 1'b0;
        mismatch_d    = 1'b0;
        attempt_d     = '0;
        phase_d       = in_data_i.cmd_unlock ? PhVerUnlock : PhVerChange;
      end
    end else begin
      // timer tick
      if (phase_q == PhAlert) begin
        tick_d = tick_inc;
        if (tick_inc >= alert_ticks_q) begin
          res.reply_valid = 1'b1;
          res.reply_code  = RcGranted;
          phase_d         = PhIdle;
        end
      end else if (phase_q == PhOpening) begin
        tick_d = tick_inc;
        if (tick_inc >= door_move_ticks_q) begin
          phase_d = PhWaitClear;
        end
      end else if (phase_q == PhWaitClear) begin
        if (!in_data_i.motion_seen) begin
          res.reply_valid = 1'b1;
          res.reply_code  = RcLocking;
          tick_d          = '0;
          phase_d         = PhClosing;
        end
      end else if (phase_q == PhClosing) begin
        tick_d = tick_inc;
        if (tick_inc >= door_move_ticks_q) begin
          res.reply_valid = 1'b1;
          res.reply_code  = RcGranted;
          phase_d         = PhIdle;
        end
      end
    end

    // levels after the update
    res.motor_drive   = (phase_d == PhOpening) ? MotorOpen :
                        (phase_d == PhClosing) ? MotorClose : MotorStop;
    res.buzzer_active = (phase_d == PhAlert) || (phase_d == PhHalted);
    res.halted        = (phase_d == PhHalted);
  end

  // control state and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q           <= PhNewPw;
      digit_index_q     <= '0;
      second_q          <= 1'b0;
      mismatch_q        <= 1'b0;
      attempt_q         <= '0;
      tick_q            <= '0;
      out_valid_q       <= 1'b0;
      door_move_ticks_q <= DoorMoveTicksRst;
      alert_ticks_q     <= AlertTicksRst;
      max_attempts_q    <= MaxAttemptsRst;
    end else begin
      if (accept) begin
        phase_q       <= phase_d;
        digit_index_q <= digit_index_d;
        second_q      <= second_d;
        mismatch_q    <= mismatch_d;
        attempt_q     <= attempt_d;
        tick_q        <= tick_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgDoorMoveTicks: door_move_ticks_q <= cfg_wdata_i[TickW-1:0];
          CfgAlertTicks:    alert_ticks_q     <= cfg_wdata_i[TickW-1:0];
          CfgMaxAttempts:   max_attempts_q    <= cfg_wdata_i[AttW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload: result and password stores
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res;
      if (fe_we) begin
        first_entry_q[digit_index_q] <= in_data_i.digit_value;
      end
      if (sp_copy) begin
        for (int i = 0; i < PasswordLen; i++) begin
          stored_pw_q[i] <= first_entry_q[i];
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for password_door_lock_controller
// Streams digits, commands, ticks and a final link error through the block
// over valid/ready, predicts every reply and output level in the bench, and
// checks each result transfer against it under several timing settings.
// ----------------------------------------------------------------------------
module tb;
  import pdl_pkg::*;

  localparam int StallLimit = 2000;  // cycles with no transfer at all
  localparam int LongHold   = 150;   // one long receiver hold-off

  // lock timing as the bench believes it is programmed
  typedef struct packed {
    logic [TickW-1:0] door;
    logic [TickW-1:0] alert;
    logic [AttW-1:0]  max_tries;
  } lock_cfg_t;

  // everything the lock remembers between events
  typedef struct packed {
    logic [PasswordLen-1:0][7:0] stored;
    logic [PasswordLen-1:0][7:0] first;
    logic                        mismatch;
    logic [2:0]                  idx;
    logic                        second;
    logic [2:0]                  tries;
    phase_e                      phase;
    logic [TickW-1:0]            ticks;
  } lock_state_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pdl_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pdl_out_t out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // traffic shaping, owned by the stimulus process
  logic send_idle_en = 1'b0;
  logic recv_idle_en = 1'b0;
  logic long_hold_due = 1'b0;

  pdl_in_t     pending_events[$];    // waiting for the driver
  pdl_out_t    expected_replies[$];  // predicted, waiting for the block
  lock_cfg_t   lock_cfg;
  lock_state_t live_lock;            // advanced on each accepted transfer
  lock_state_t plan_lock;            // advanced as stimulus is planned
  int          planned_events = 0;

  int send_gap = 0;
  int hold_left = 0;
  logic long_hold_done = 1'b0;
  int idle_cycles = 0;
  int bad_results = 0;
  int events_taken = 0;
  int replies_checked = 0;
  int grants = 0, denials = 0, alerts = 0, lockings = 0;

  password_door_lock_controller u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Lock behavior: one event in, one result out, state updated in place.
  // --------------------------------------------------------------------------
  task automatic step_lock(inout lock_state_t s, input lock_cfg_t c, input pdl_in_t ev,
                           output pdl_out_t r);
    logic [2:0] pos;
    logic       last_digit;
    pos = s.idx;
    last_digit = (int'(s.idx) + 1) >= int'(PasswordLen);
    r = '0;
    if (s.phase != PhHalted) begin
      case (ev.action)
        ActLinkErr: s.phase = PhHalted;
        ActDigit: begin
          if (s.phase == PhNewPw && !s.second) begin
            // first of the two entries is only recorded
            s.first[pos] = ev.digit_value;
            if (last_digit) begin
              s.idx = '0;
              s.second = 1'b1;
              s.mismatch = 1'b0;
            end else s.idx = s.idx + 3'd1;
          end else if (s.phase == PhNewPw) begin
            if (s.first[pos] != ev.digit_value) s.mismatch = 1'b1;
            if (last_digit) begin
              r.reply_valid = 1'b1;
              if (!s.mismatch) begin
                s.stored = s.first;
                r.reply_code = RcGranted;
                s.phase = PhIdle;
              end else r.reply_code = RcDenied;
              {s.idx, s.second, s.mismatch} = '0;
            end else s.idx = s.idx + 3'd1;
          end else if (s.phase == PhVerUnlock || s.phase == PhVerChange) begin
            s.first[pos] = ev.digit_value;
            if (s.stored[pos] != ev.digit_value) s.mismatch = 1'b1;
            if (last_digit) begin
              r.reply_valid = 1'b1;
              if (!s.mismatch) begin
                r.reply_code = RcGranted;
                s.ticks = '0;
                if (s.phase == PhVerUnlock) s.phase = PhOpening;
                else s.phase = PhNewPw;
              end else if (int'(s.tries) + 1 >= int'(c.max_tries)) begin
                // zero allowed attempts behaves like one
                r.reply_code = RcAlert;
                s.ticks = '0;
                s.phase = PhAlert;
              end else begin
                r.reply_code = RcDenied;
                s.tries = s.tries + 3'd1;
              end
              {s.idx, s.second, s.mismatch} = '0;
            end else s.idx = s.idx + 3'd1;
          end
        end
        ActCommand: begin
          if (s.phase == PhIdle) begin
            {s.idx, s.second, s.mismatch} = '0;
            s.tries = '0;
            if (ev.cmd_unlock) s.phase = PhVerUnlock;
            else s.phase = PhVerChange;
          end
        end
        default: begin
          case (s.phase)
            PhAlert, PhOpening, PhClosing: begin
              // a zero limit is reached on the first tick
              s.ticks = s.ticks + 1'b1;
              if (s.ticks >= ((s.phase == PhAlert) ? c.alert : c.door)) begin
                if (s.phase == PhOpening) s.phase = PhWaitClear;
                else begin
                  r.reply_valid = 1'b1;
                  r.reply_code = RcGranted;
                  s.phase = PhIdle;
                end
              end
            end
            PhWaitClear: begin
              if (!ev.motion_seen) begin
                r.reply_valid = 1'b1;
                r.reply_code = RcLocking;
                s.ticks = '0;
                s.phase = PhClosing;
              end
            end
            default: ;
          endcase
        end
      endcase
    end
    r.motor_drive = (s.phase == PhOpening) ? MotorOpen :
                    (s.phase == PhClosing) ? MotorClose : MotorStop;
    r.buzzer_active = (s.phase == PhAlert || s.phase == PhHalted);
    r.halted = (s.phase == PhHalted);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus planning. Every planned event also runs through plan_lock so
  // that the next choice knows which phase the lock will be in.
  // --------------------------------------------------------------------------
  function automatic pdl_in_t mk_event(input logic [1:0] act);
    pdl_in_t ev;
    ev.action      = act;
    ev.digit_value = 8'($urandom);
    ev.cmd_unlock  = 1'($urandom);
    ev.motion_seen = 1'($urandom);
    return ev;
  endfunction

  task automatic queue_event(input pdl_in_t ev);
    pdl_out_t unused;
    step_lock(plan_lock, lock_cfg, ev, unused);
    pending_events.push_back(ev);
    planned_events++;
  endtask

  // one entry of PasswordLen digits; a stray tick or command goes in
  // before digit noise_at (no stray event when noise_at is out of range)
  task automatic queue_code(input logic [PasswordLen-1:0][7:0] code, input int noise_at);
    pdl_in_t ev;
    int i;
    for (i = 0; i < PasswordLen; i++) begin
      if (i == noise_at) queue_event(mk_event(i[0] ? ActCommand : ActTick));
      ev = mk_event(ActDigit);
      ev.digit_value = code[i];
      queue_event(ev);
    end
  endtask

  function automatic logic [PasswordLen-1:0][7:0] wrong_code();
    logic [PasswordLen-1:0][7:0] code;
    int pos;
    int i;
    code = plan_lock.stored;
    if ($urandom_range(0, 3) == 0) begin
      for (i = 0; i < PasswordLen; i++) code[i] = 8'($urandom);
    end else begin
      pos = $urandom_range(0, PasswordLen - 1);
      code[pos] = code[pos] ^ 8'($urandom_range(1, 255));
    end
    return code;
  endfunction

  // ticks (with a little ignored noise) until the lock is back at idle
  task automatic queue_ticks_to_idle();
    pdl_in_t ev;
    while (plan_lock.phase inside {PhAlert, PhOpening, PhWaitClear, PhClosing}) begin
      if ($urandom_range(0, 11) == 0) begin
        queue_event(mk_event($urandom_range(0, 1) ? ActDigit : ActCommand));
      end else begin
        ev = mk_event(ActTick);
        // door stays blocked by motion for a few ticks now and then
        if (plan_lock.phase == PhWaitClear) ev.motion_seen = ($urandom_range(0, 2) != 0);
        queue_event(ev);
      end
    end
  endtask

  task automatic queue_new_password();
    logic [PasswordLen-1:0][7:0] code, again;
    int i;
    int pos;
    for (i = 0; i < PasswordLen; i++) begin
      case ($urandom_range(0, 7))
        0:       code[i] = 8'h00;
        1:       code[i] = 8'hFF;
        default: code[i] = 8'($urandom);
      endcase
    end
    again = code;
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, PasswordLen - 1);
      again[pos] = again[pos] ^ 8'($urandom_range(1, 255));
    end
    queue_code(code, $urandom_range(0, 9));
    queue_code(again, $urandom_range(0, 9));
  endtask

  // command from idle, `misses` wrong entries, then the right one
  task automatic queue_command(input logic unlock, input int misses);
    pdl_in_t ev;
    int left;
    left = misses;
    if ($urandom_range(0, 3) == 0) queue_event(mk_event($urandom_range(0, 1) ? ActDigit : ActTick));
    ev = mk_event(ActCommand);
    ev.cmd_unlock = unlock;
    queue_event(ev);
    while (plan_lock.phase == PhVerUnlock || plan_lock.phase == PhVerChange) begin
      if (left > 0) queue_code(wrong_code(), $urandom_range(0, 9));
      else queue_code(plan_lock.stored, $urandom_range(0, 9));
      left--;
    end
    queue_ticks_to_idle();
  endtask

  task automatic queue_sessions(input int n);
    int start;
    start = planned_events;
    while (planned_events - start < n || plan_lock.phase != PhIdle) begin
      if (plan_lock.phase == PhNewPw) queue_new_password();
      else queue_command(1'($urandom), ($urandom_range(0, 3) == 0) ? 7 : $urandom_range(0, 2));
    end
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CfgDoorMoveTicks: lock_cfg.door = val;
      CfgAlertTicks:    lock_cfg.alert = val;
      default:          lock_cfg.max_tries = val[AttW-1:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // registers only change with nothing in flight
  task automatic set_timing(input int door, input int alert, input int tries);
    wait_drained();
    write_reg(CfgDoorMoveTicks, CfgDataW'(door));
    write_reg(CfgAlertTicks, CfgDataW'(alert));
    write_reg(CfgMaxAttempts, CfgDataW'(tries));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [PasswordLen-1:0][7:0] code;
    pdl_in_t ev;

    lock_cfg = '{door: DoorMoveTicksRst, alert: AlertTicksRst, max_tries: MaxAttemptsRst};
    plan_lock = '0;
    plan_lock.phase = PhNewPw;
    live_lock = plan_lock;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_en <= 1'b1;
    recv_idle_en <= 1'b1;

    // directed, reset timing: mismatched pair with extreme digits and stray
    // tick/command inside the entries, then a matching pair, then events
    // that idle must ignore
    code = {8'h01, 8'hA5, 8'h5A, 8'hFF, 8'h00};
    queue_code(code, 2);
    code[4] = 8'h81;
    queue_code(code, 3);
    code[4] = 8'h01;
    queue_code(code, -1);
    queue_code(code, -1);
    queue_event(mk_event(ActDigit));
    ev = mk_event(ActTick);
    ev.motion_seen = 1'b1;
    queue_event(ev);
    queue_sessions(400);

    // zero registers must act like one
    set_timing(0, 0, 0);
    queue_sessions(350);

    set_timing(1, 1, 1);
    send_idle_en <= 1'b1;
    recv_idle_en <= 1'b0;
    queue_sessions(350);

    // most attempts; receiver stops for a long while so the input backs up
    set_timing(2, 5, 7);
    send_idle_en <= 1'b0;
    recv_idle_en <= 1'b1;
    queue_sessions(350);
    long_hold_due <= 1'b1;

    set_timing($urandom_range(1, 8), $urandom_range(1, 12), $urandom_range(2, 6));
    send_idle_en <= 1'b1;
    recv_idle_en <= 1'b1;
    queue_sessions(350);

    // last stretch at full rate: short door and alert timers with a single
    // allowed attempt, then a link error mid-entry freezes the block for good
    set_timing(6, 9, 1);
    send_idle_en <= 1'b0;
    recv_idle_en <= 1'b0;
    queue_command(1'b1, 0);
    queue_command(1'b1, 1);
    ev = mk_event(ActCommand);
    ev.cmd_unlock = 1'b1;
    queue_event(ev);
    ev = mk_event(ActDigit);
    ev.digit_value = plan_lock.stored[0];
    queue_event(ev);
    queue_event(mk_event(ActLinkErr));
    queue_event(mk_event(ActDigit));
    queue_event(mk_event(ActCommand));
    queue_event(mk_event(ActTick));
    queue_event(mk_event(ActLinkErr));

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Run: %0d events, %0d results checked over six timing settings", events_taken,
             replies_checked);
    $display("Replies: %0d granted, %0d denied, %0d alert, %0d locking", grants, denials,
             alerts, lockings);
    if (bad_results == 0 && expected_replies.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d bad results, %0d still expected", bad_results, expected_replies.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: one event per transfer, optional short gaps after a transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_events.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_events.pop_front();
        if (send_idle_en && $urandom_range(0, 6) == 0) send_gap <= $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: short stall bursts, plus one long hold-off on request.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_due && !long_hold_done) begin
      out_ready <= 1'b0;
      hold_left <= LongHold - 1;
      long_hold_done <= 1'b1;
    end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      hold_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Prediction on every input transfer.
  always @(posedge clk) begin
    pdl_out_t want;
    if (rst_n && in_valid && in_ready) begin
      step_lock(live_lock, lock_cfg, in_data, want);
      expected_replies.push_back(want);
      events_taken++;
    end
  end

  // Checker on every result transfer, oldest prediction first.
  always @(posedge clk) begin
    pdl_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: valid=%0d code=%0d motor=%0d buzz=%0d halt=%0d",
                   out_data.reply_valid, out_data.reply_code, out_data.motor_drive,
                   out_data.buzzer_active, out_data.halted);
      end else begin
        want = expected_replies.pop_front();
        replies_checked++;
        if (want.reply_valid) begin
          case (want.reply_code)
            RcGranted: grants++;
            RcDenied:  denials++;
            RcAlert:   alerts++;
            default:   lockings++;
          endcase
        end
        if (out_data.reply_valid !== want.reply_valid || out_data.reply_code !== want.reply_code
            || out_data.motor_drive !== want.motor_drive
            || out_data.buzzer_active !== want.buzzer_active
            || out_data.halted !== want.halted) begin
          bad_results++;
          if (bad_results <= 10)
            $display("result %0d: want v=%0d c=%0d m=%0d b=%0d h=%0d, got v=%0d c=%0d m=%0d b=%0d h=%0d",
                     replies_checked, want.reply_valid, want.reply_code, want.motor_drive,
                     want.buzzer_active, want.halted, out_data.reply_valid, out_data.reply_code,
                     out_data.motor_drive, out_data.buzzer_active, out_data.halted);
        end
      end
    end
  end

  // Watchdog: too long without any transfer means the block is stuck.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

FILE: sim.f
sv/pdl_pkg.sv
sv/password_door_lock_controller.sv
tb/sv/tb.sv
